/* hdl/kwl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwl_pkg
// Shared types, constants and keyword lookup for the keyword lexer.
// ----------------------------------------------------------------------------
package kwl_pkg;

	localparam int KW_MAX_LEN  = 5;
	localparam int OFFSET_BITS = 16;
	localparam int VALUE_BITS  = 31;
	localparam int LEN_BITS    = 16;
	localparam int KW_TEXT_LEN = 5;
	localparam int KW_COUNT    = 8;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [LEN_BITS-1:0]   LEN_MAX   = {LEN_BITS{1'b1}};
	localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

	// token kinds
	localparam logic [4:0] TK_WORD   = 5'd0;
	localparam logic [4:0] TK_STRING = 5'd1;
	localparam logic [4:0] TK_NUMBER = 5'd2;
	localparam logic [4:0] TK_TRUE   = 5'd3;
	localparam logic [4:0] TK_FALSE  = 5'd4;
	localparam logic [4:0] TK_NONE   = 5'd5;
	localparam logic [4:0] TK_EQUAL  = 5'd6;
	localparam logic [4:0] TK_LESS   = 5'd8;
	localparam logic [4:0] TK_GREATER = 5'd9;
	localparam logic [4:0] TK_PLUS   = 5'd12;
	localparam logic [4:0] TK_MINUS  = 5'd13;
	localparam logic [4:0] TK_STAR   = 5'd14;
	localparam logic [4:0] TK_SLASH  = 5'd15;
	localparam logic [4:0] TK_BANG   = 5'd16;
	localparam logic [4:0] TK_SEMI   = 5'd17;
	localparam logic [4:0] TK_QUOTE  = 5'd19;
	localparam logic [4:0] TK_LPAREN = 5'd20;
	localparam logic [4:0] TK_RPAREN = 5'd21;
	localparam logic [4:0] TK_PRINT  = 5'd22;
	localparam logic [4:0] TK_VAR    = 5'd23;
	localparam logic [4:0] TK_INPUT  = 5'd24;
	localparam logic [4:0] TK_IF     = 5'd25;
	localparam logic [4:0] TK_ELSE   = 5'd26;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_UNTERM   = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW = 2'd2;

	typedef logic [KW_MAX_LEN-1:0][7:0]  kw_chars_t;
	typedef logic [KW_TEXT_LEN-1:0][7:0] kw_text_t;

	typedef struct packed {
		logic [7:0] source_byte;
		logic       end_of_input;
	} src_t;

	typedef struct packed {
		logic [4:0]            token_kind;
		logic [VALUE_BITS-1:0] number_value;
		logic [OFFSET_BITS-1:0] start_offset;
		logic [LEN_BITS-1:0]   token_length;
		logic [1:0]            error_code;
		logic                  last_of_run;
	} tok_t;

	typedef struct packed {
		logic [1:0] count;
		tok_t       first;
		tok_t       second;
	} kwl_push_t;

	// character j of a keyword sits at index j
	localparam kw_text_t KW_TEXT [KW_COUNT] = '{
		{8'h00, 8'h00, "r", "a", "v"},
		{"t", "n", "i", "r", "p"},
		{"t", "u", "p", "n", "i"},
		{8'h00, "e", "u", "r", "t"},
		{"e", "s", "l", "a", "f"},
		{8'h00, "e", "n", "o", "n"},
		{8'h00, 8'h00, 8'h00, "f", "i"},
		{8'h00, "e", "s", "l", "e"}
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd3, 3'd5, 3'd5, 3'd4, 3'd5, 3'd4, 3'd2, 3'd4};
	localparam logic [4:0] KW_KIND [KW_COUNT] = '{
		TK_VAR, TK_PRINT, TK_INPUT, TK_TRUE, TK_FALSE, TK_NONE, TK_IF, TK_ELSE
	};

	function automatic logic [4:0] word_kind(input kw_chars_t chars,
	                                         input logic [LEN_BITS-1:0] len);
		logic [4:0] kind;
		logic       hit;
		kind = TK_WORD;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			hit = (len == LEN_BITS'(KW_LEN[i]));
			for (int j = 0; j < KW_TEXT_LEN; j++) begin
				if (j < int'(KW_LEN[i]) && chars[j] != KW_TEXT[i][j])
					hit = 1'b0;
			end
			if (hit)
				kind = KW_KIND[i];
		end
		return kind;
	endfunction

	function automatic logic [5:0] op_kind(input logic [7:0] c);
		// bit 5 set: known operator
		case (c)
			"+":     return {1'b1, TK_PLUS};
			"-":     return {1'b1, TK_MINUS};
			"/":     return {1'b1, TK_SLASH};
			"*":     return {1'b1, TK_STAR};
			"=":     return {1'b1, TK_EQUAL};
			">":     return {1'b1, TK_GREATER};
			"<":     return {1'b1, TK_LESS};
			"!":     return {1'b1, TK_BANG};
			";":     return {1'b1, TK_SEMI};
			"(":     return {1'b1, TK_LPAREN};
			")":     return {1'b1, TK_RPAREN};
			default: return 6'd0;
		endcase
	endfunction

endpackage

/* hdl/kwl_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwl_core
// Scanner state and per-byte token decision; produces up to two tokens.
// ----------------------------------------------------------------------------
module kwl_core
	import kwl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  src_t      item,
	output kwl_push_t push
);

	typedef enum logic [1:0] {MODE_IDLE, MODE_WORD, MODE_NUMBER, MODE_STRING} mode_t;

	mode_t                   mode_q, mode_d;
	kw_chars_t               chars_q, chars_d;
	logic [LEN_BITS-1:0]     len_q, len_d;
	logic [VALUE_BITS-1:0]   acc_q, acc_d;
	logic                    ovf_q, ovf_d;
	logic [OFFSET_BITS-1:0]  pos_q, pos_d;
	logic [OFFSET_BITS-1:0]  start_q, start_d;

	logic [7:0]              c;
	logic                    is_letter, is_digit, is_quote;
	logic [3:0]              digit;
	logic [VALUE_BITS+3:0]   acc_next;
	logic [LEN_BITS-1:0]     len_bump;
	logic [5:0]              op;
	tok_t                    pend, e0, e1;
	logic                    e0_v, e1_v;

	always_comb begin
		c         = item.source_byte;
		is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
		is_digit  = (c >= "0" && c <= "9");
		is_quote  = (c == 8'h22);
		digit     = 4'(c - "0");
		acc_next  = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + (VALUE_BITS+4)'(digit);
		len_bump  = (len_q != LEN_MAX) ? len_q + 1'b1 : len_q;
		op        = op_kind(c);

		pend = '0;
		pend.start_offset = start_q;
		pend.token_length = len_q;
		case (mode_q)
			MODE_WORD:   pend.token_kind = word_kind(chars_q, len_q);
			MODE_NUMBER: begin
				pend.token_kind   = TK_NUMBER;
				pend.number_value = acc_q;
				pend.error_code   = ovf_q ? ERR_OVERFLOW : ERR_NONE;
			end
			default: begin
				pend.token_kind = TK_STRING;
				pend.error_code = ERR_UNTERM;
			end
		endcase

		mode_d  = mode_q;
		chars_d = chars_q;
		len_d   = len_q;
		acc_d   = acc_q;
		ovf_d   = ovf_q;
		start_d = start_q;
		pos_d   = pos_q + 1'b1;
		e0_v    = 1'b0;
		e1_v    = 1'b0;
		e0      = pend;
		e1      = '0;
		e1.start_offset = pos_q;
		e1.token_length = LEN_BITS'(1);

		if (item.end_of_input) begin
			e0_v    = (mode_q != MODE_IDLE);
			mode_d  = MODE_IDLE;
			chars_d = '0;
			len_d   = '0;
			acc_d   = '0;
			ovf_d   = 1'b0;
			pos_d   = '0;
			start_d = '0;
		end else if (mode_q == MODE_STRING) begin
			if (is_quote) begin
				e0_v          = 1'b1;
				e0.error_code = ERR_NONE;
				e1_v          = 1'b1;
				e1.token_kind = TK_QUOTE;
				mode_d        = MODE_IDLE;
			end else begin
				len_d = len_bump;
			end
		end else if (mode_q == MODE_WORD && is_letter) begin
			for (int i = 0; i < KW_MAX_LEN; i++) begin
				if (len_q == LEN_BITS'(i))
					chars_d[i] = c;
			end
			len_d = len_bump;
		end else if (mode_q == MODE_NUMBER && is_digit) begin
			if (acc_next > (VALUE_BITS+4)'(VALUE_MAX)) begin
				acc_d = VALUE_MAX;
				ovf_d = 1'b1;
			end else begin
				acc_d = acc_next[VALUE_BITS-1:0];
			end
			len_d = len_bump;
		end else begin
			e0_v   = (mode_q != MODE_IDLE);
			mode_d = MODE_IDLE;
			if (is_letter) begin
				mode_d     = MODE_WORD;
				start_d    = pos_q;
				len_d      = LEN_BITS'(1);
				chars_d[0] = c;
			end else if (is_digit) begin
				mode_d  = MODE_NUMBER;
				start_d = pos_q;
				len_d   = LEN_BITS'(1);
				acc_d   = VALUE_BITS'(digit);
				ovf_d   = 1'b0;
			end else if (is_quote) begin
				e1_v          = 1'b1;
				e1.token_kind = TK_QUOTE;
				mode_d        = MODE_STRING;
				start_d       = pos_q + 1'b1;
				len_d         = '0;
			end else if (op[5]) begin
				e1_v          = 1'b1;
				e1.token_kind = op[4:0];
			end
		end

		push = '0;
		if (e0_v && e1_v) begin
			push.count  = 2'd2;
			push.first  = e0;
			push.second = e1;
			push.second.last_of_run = 1'b1;
		end else if (e0_v) begin
			push.count = 2'd1;
			push.first = e0;
			push.first.last_of_run = 1'b1;
		end else if (e1_v) begin
			push.count = 2'd1;
			push.first = e1;
			push.first.last_of_run = 1'b1;
		end
		if (!fire)
			push.count = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			chars_q <= '0;
			len_q   <= '0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			pos_q   <= '0;
			start_q <= '0;
		end else if (fire) begin
			mode_q  <= mode_d;
			chars_q <= chars_d;
			len_q   <= len_d;
			acc_q   <= acc_d;
			ovf_q   <= ovf_d;
			pos_q   <= pos_d;
			start_q <= start_d;
		end
	end

endmodule

/* hdl/kwl_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwl_queue
// Token result queue: takes up to two tokens per cycle, hands out one while tok_ready is high.
// ----------------------------------------------------------------------------
module kwl_queue
	import kwl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  kwl_push_t push,
	output logic      room,
	output logic      tok_valid,
	input  logic      tok_ready,
	output tok_t      tok
);

	tok_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] rd_q, wr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              pop;

	assign tok_valid = (cnt_q != '0);
	assign tok       = slot_q[rd_q];
	assign pop       = tok_valid && tok_ready;
	assign room      = (cnt_q <= QCNT_W'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			slot_q[wr_q] <= push.first;
		if (push.count == 2'd2)
			slot_q[wr_q + 1'b1] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(push.count);
			rd_q  <= rd_q + QPTR_W'(pop);
			cnt_q <= cnt_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

endmodule

/* hdl/keyword_lexer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_lexer
// Streaming byte-to-token scanner with keyword matching and number values.
// ----------------------------------------------------------------------------
// Order: tokens are registered into the queue and offered on tok in order.
// Throughput: one byte per cycle; a byte may yield two tokens, drained one per
// cycle while tok_ready is high through a four-entry token queue, which holds
// src_ready low while fewer than two entries are free.
// Reset: arst_n clears scanner state to idle at offset 0 and empties the queue.
// ----------------------------------------------------------------------------
module keyword_lexer
	import kwl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic src_valid,
	output logic src_ready,
	input  src_t src,
	output logic tok_valid,
	input  logic tok_ready,
	output tok_t tok
);

	kwl_push_t push;
	logic      fire;

	assign fire = src_valid && src_ready;

	kwl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (src),
		.push   (push)
	);

	kwl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (src_ready),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok       (tok)
	);

endmodule
